@@ rtl/core/spct_pkg.sv @@
// Shared types, constants and helpers for the SNP pair contingency table block.
package spct_pkg;

    localparam int WORD_W        = 64;  // width of one plane word on the port
    localparam int DEF_WORD_BITS = 64;  // samples used in each word
    localparam int NUM_PLANES    = 3;
    localparam int NUM_LANES     = NUM_PLANES * NUM_PLANES;
    localparam int NUM_CTR       = 2 * NUM_LANES;
    localparam int CNT_W         = 21;
    localparam int CELL_W        = 22;
    localparam int IDX_W         = 5;
    localparam int NUM_CELLS     = 29;

    localparam logic [IDX_W-1:0]  IDX_COL_CTRL = IDX_W'(27);
    localparam logic [IDX_W-1:0]  IDX_COL_CASE = IDX_W'(28);
    localparam logic [CNT_W-1:0]  CNT_MAX      = '1;
    localparam logic [CELL_W-1:0] CELL_MAX     = '1;

    // Position of a cell inside its genotype-pair triple
    typedef enum logic [1:0] {
        SUB_CTRL,
        SUB_CASE,
        SUB_ROW
    } t_sub;

    typedef logic [NUM_CTR-1:0][CNT_W-1:0] t_cnt_arr;

    function automatic logic [CELL_W-1:0] sat_add_cell(input logic [CELL_W-1:0] a,
                                                       input logic [CELL_W-1:0] b);
        logic [CELL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CELL_W] ? CELL_MAX : s[CELL_W-1:0];
    endfunction

endpackage

@@ rtl/core/spct_if.sv @@
// Handshake channels: genotype word input and table cell output.
interface spct_in_if;
    logic                        valid;
    logic                        ready;
    logic [spct_pkg::WORD_W-1:0] a_major_word;
    logic [spct_pkg::WORD_W-1:0] a_het_word;
    logic [spct_pkg::WORD_W-1:0] a_minor_word;
    logic [spct_pkg::WORD_W-1:0] b_major_word;
    logic [spct_pkg::WORD_W-1:0] b_het_word;
    logic [spct_pkg::WORD_W-1:0] b_minor_word;
    logic                        is_case;
    logic                        last_word;

    modport source (
        output valid, a_major_word, a_het_word, a_minor_word,
               b_major_word, b_het_word, b_minor_word, is_case, last_word,
        input  ready
    );
    modport sink (
        input  valid, a_major_word, a_het_word, a_minor_word,
               b_major_word, b_het_word, b_minor_word, is_case, last_word,
        output ready
    );
endinterface

interface spct_out_if;
    logic                        valid;
    logic                        ready;
    logic [spct_pkg::IDX_W-1:0]  cell_index;
    logic [spct_pkg::CELL_W-1:0] cell_count;
    logic                        last_cell;

    modport source (output valid, cell_index, cell_count, last_cell, input ready);
    modport sink   (input  valid, cell_index, cell_count, last_cell, output ready);
endinterface

@@ rtl/core/spct_lane.sv @@
// One lane: registered popcount of the AND of two genotype plane words.
module spct_lane #(
    parameter int WORD_BITS = spct_pkg::DEF_WORD_BITS,
    localparam int PC_W     = $clog2(WORD_BITS + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [spct_pkg::WORD_W-1:0] i_a_word,
    input  logic [spct_pkg::WORD_W-1:0] i_b_word,
    output logic [PC_W-1:0]             o_count
);
    import spct_pkg::*;

    localparam logic [WORD_W-1:0] WMASK = {WORD_W{1'b1}} >> (WORD_W - WORD_BITS);
    localparam logic [WORD_W-1:0] M1    = {(WORD_W / 2){2'b01}};
    localparam logic [WORD_W-1:0] M2    = {(WORD_W / 4){4'b0011}};
    localparam logic [WORD_W-1:0] M4    = {(WORD_W / 8){8'h0f}};

    logic [WORD_W-1:0] w_and;
    logic [WORD_W-1:0] w_s1, w_s2, w_s3, w_s4, w_s5, w_s6;
    logic [PC_W-1:0]   r_count;

    // SWAR bit count: pairs, nibbles, bytes, then fold the bytes together
    always_comb begin
        w_and = i_a_word & i_b_word & WMASK;
        w_s1  = w_and - ((w_and >> 1) & M1);
        w_s2  = (w_s1 & M2) + ((w_s1 >> 2) & M2);
        w_s3  = (w_s2 + (w_s2 >> 4)) & M4;
        w_s4  = w_s3 + (w_s3 >> 8);
        w_s5  = w_s4 + (w_s4 >> 16);
        w_s6  = w_s5 + (w_s5 >> 32);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_count <= w_s6[PC_W-1:0];
        end
    end

    assign o_count = r_count;
endmodule

@@ rtl/core/spct_emit.sv @@
// Table builder: holds a counter snapshot and sends the 29 cells with totals.
module spct_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  spct_pkg::t_cnt_arr i_snap,
    output logic               o_busy,
    spct_out_if.source         o_out_ch
);
    import spct_pkg::*;

    t_cnt_arr          r_snap;
    logic              r_busy;
    logic [IDX_W-1:0]  r_idx;
    t_sub              r_sub;
    logic [CELL_W-1:0] r_col0, r_col1;
    logic              r_o_valid;
    logic [IDX_W-1:0]  r_o_index;
    logic [CELL_W-1:0] r_o_count;
    logic              r_o_last;

    logic              w_out_free, w_step, w_is_col;
    logic [CELL_W-1:0] w_c0, w_c1, w_rt, w_cell;

    always_comb begin
        w_out_free = !r_o_valid || o_out_ch.ready;
        w_step     = r_busy && w_out_free;
        w_is_col   = (r_idx == IDX_COL_CTRL) || (r_idx == IDX_COL_CASE);
        // entries 0 and 1 always hold the current pair's control and case counts
        w_c0       = {1'b0, r_snap[0]} + CELL_W'(1);
        w_c1       = {1'b0, r_snap[1]} + CELL_W'(1);
        w_rt       = sat_add_cell(w_c0, w_c1);
        if (r_idx == IDX_COL_CTRL) begin
            w_cell = r_col0;
        end else if (r_idx == IDX_COL_CASE) begin
            w_cell = r_col1;
        end else begin
            unique case (r_sub)
                SUB_CTRL: w_cell = w_c0;
                SUB_CASE: w_cell = w_c1;
                SUB_ROW:  w_cell = w_rt;
                default:  w_cell = w_rt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_idx     <= '0;
            r_sub     <= SUB_CTRL;
            r_o_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_sub  <= SUB_CTRL;
            end else if (w_step) begin
                if (r_idx == IDX_COL_CASE) begin
                    r_busy <= 1'b0;
                end
                r_idx <= r_idx + IDX_W'(1);
                if (!w_is_col) begin
                    r_sub <= (r_sub == SUB_ROW) ? SUB_CTRL : t_sub'(r_sub + 2'd1);
                end
            end
            if (w_out_free) begin
                r_o_valid <= w_step;
            end
        end
    end

    // payload side: snapshot shift and column totals
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_snap <= i_snap;
            r_col0 <= '0;
            r_col1 <= '0;
        end else if (w_step && !w_is_col) begin
            if (r_sub == SUB_CTRL) begin
                r_col0 <= sat_add_cell(r_col0, w_c0);
            end
            if (r_sub == SUB_CASE) begin
                r_col1 <= sat_add_cell(r_col1, w_c1);
            end
            if (r_sub == SUB_ROW) begin
                for (int i = 0; i < NUM_CTR - 2; i++) begin
                    r_snap[i] <= r_snap[i + 2];
                end
            end
        end
        if (w_step) begin
            r_o_index <= r_idx;
            r_o_count <= w_cell;
            r_o_last  <= (r_idx == IDX_COL_CASE);
        end
    end

    assign o_busy              = r_busy;
    assign o_out_ch.valid      = r_o_valid;
    assign o_out_ch.cell_index = r_o_index;
    assign o_out_ch.cell_count = r_o_count;
    assign o_out_ch.last_cell  = r_o_last;
endmodule

@@ rtl/core/snp_pair_contingency_table_core.sv @@
// SNP pair contingency table: nine popcount lanes, group counters, table builder.
// Throughput: one word per cycle except while a last word waits; a table of 29 cells goes out
// at one cell per cycle while the output is ready. After the last word's transfer the first cell
// passes the lane register, the counter merge into the builder's snapshot and the output register.
// A last word waits in the merge stage, holding off the input, while the previous table is sent.
// Reset (synchronous, active low) clears the counters and empties both channels.
module snp_pair_contingency_table_core #(
    parameter int WORD_BITS = spct_pkg::DEF_WORD_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spct_in_if.sink    i_in_ch,
    spct_out_if.source o_out_ch
);
    import spct_pkg::*;

    localparam int PC_W = $clog2(WORD_BITS + 1);

    logic [WORD_W-1:0] w_pa [NUM_PLANES];
    logic [WORD_W-1:0] w_pb [NUM_PLANES];
    logic [PC_W-1:0]   w_pc [NUM_LANES];

    logic     r_s1_valid, r_s1_case, r_s1_last;
    t_cnt_arr r_cnt, n_cnt;
    logic     w_in_xfer, w_s1_adv, w_load, w_busy;
    logic [CNT_W:0] w_sum [NUM_CTR];

    assign w_pa[0] = i_in_ch.a_major_word;
    assign w_pa[1] = i_in_ch.a_het_word;
    assign w_pa[2] = i_in_ch.a_minor_word;
    assign w_pb[0] = i_in_ch.b_major_word;
    assign w_pb[1] = i_in_ch.b_het_word;
    assign w_pb[2] = i_in_ch.b_minor_word;

    for (genvar p = 0; p < NUM_LANES; p++) begin : g_lane
        spct_lane #(.WORD_BITS(WORD_BITS)) u_lane (
            .i_clk    (i_clk),
            .i_en     (w_in_xfer),
            .i_a_word (w_pa[p / NUM_PLANES]),
            .i_b_word (w_pb[p % NUM_PLANES]),
            .o_count  (w_pc[p])
        );
    end

    always_comb begin
        w_s1_adv       = r_s1_valid && (!r_s1_last || !w_busy);
        i_in_ch.ready  = !r_s1_valid || w_s1_adv;
        w_in_xfer      = i_in_ch.valid && i_in_ch.ready;
        w_load         = w_s1_adv && r_s1_last;
        // counter 2*p+g takes lane p when the word belongs to group g
        for (int i = 0; i < NUM_CTR; i++) begin
            w_sum[i] = {1'b0, r_cnt[i]};
            if (i[0] == r_s1_case) begin
                w_sum[i] = w_sum[i] + (CNT_W + 1)'(w_pc[i / 2]);
            end
            n_cnt[i] = w_sum[i][CNT_W] ? CNT_MAX : w_sum[i][CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_cnt      <= '0;
        end else begin
            if (w_in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_cnt <= r_s1_last ? '0 : n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_case <= i_in_ch.is_case;
            r_s1_last <= i_in_ch.last_word;
        end
    end

    spct_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_snap   (n_cnt),
        .o_busy   (w_busy),
        .o_out_ch (o_out_ch)
    );
endmodule

@@ rtl/core/spct_check.sv @@
// Port-level checks on the table output stream, bound to the core.
module spct_check (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [spct_pkg::IDX_W-1:0]  i_cell_index,
    input logic [spct_pkg::CELL_W-1:0] i_cell_count,
    input logic                        i_last_cell
);
    import spct_pkg::*;

    logic [IDX_W-1:0] r_exp_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_idx <= '0;
        end else if (i_out_valid && i_out_ready) begin
            r_exp_idx <= (i_cell_index == IDX_COL_CASE) ? '0 : i_cell_index + IDX_W'(1);
        end
    end

    a_idx_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_cell_index == r_exp_idx)
        else $error("cell index out of order");

    a_last_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_last_cell == (i_cell_index == IDX_COL_CASE))
        else $error("last_cell not on final cell");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_cell_count != '0)
        else $error("cell count missing the +1 correction");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_cell_index) && $stable(i_cell_count))
        else $error("stalled transfer changed");
endmodule

bind snp_pair_contingency_table_core spct_check u_spct_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out_ch.valid),
    .i_out_ready  (o_out_ch.ready),
    .i_cell_index (o_out_ch.cell_index),
    .i_cell_count (o_out_ch.cell_count),
    .i_last_cell  (o_out_ch.last_cell)
);
